// ===== design/lfvg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light fan vertex generator package
// Transaction types, vertex descriptors and datapath widths shared by the
// sequencer and the transform pipeline.
// ----------------------------------------------------------------------------
package lfvg_pkg;

  localparam int CW   = 24;  // Q15.8 coordinate width
  localparam int RW   = 18;  // sine ROM entry width, 1.0 = 65536
  localparam int MXW  = 41;  // radius * sine
  localparam int LXW  = 42;  // local x, 24 fraction bits
  localparam int LYW  = 48;  // local y, 24 fraction bits
  localparam int SUMW = 64;  // rotated coordinate, 38 fraction bits

  typedef enum logic [1:0] {
    OP_POINT  = 2'd0,
    OP_SPOT   = 2'd1,
    OP_DIRECT = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] intensity;
    logic signed [23:0] radius;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [23:0] shift;
    logic signed [15:0] aspect;
    logic signed [23:0] beam_length;
  } lfvg_req_t;

  typedef struct packed {
    logic               fan_start;
    logic signed [23:0] vertex_x;
    logic signed [23:0] vertex_y;
    logic [7:0]         alpha;
    logic               last;
  } lfvg_res_t;

  typedef struct packed {
    logic       fan_start;
    logic [7:0] alpha;
    logic       last;
  } lfvg_tag_t;

  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } lfvg_frame_t;

  typedef struct packed {
    lfvg_tag_t          tag;
    lfvg_frame_t        frame;
    logic signed [23:0] radius;
    logic signed [15:0] aspect;
    logic signed [23:0] offset;
    logic               use_asp;
    logic [4:0]         idx_x;
    logic [4:0]         idx_y;
  } lfvg_vtx_t;

endpackage

// ===== design/lfvg_xform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light fan vertex transform pipeline
// Turns one vertex descriptor per cycle into a rounded, saturated Q15.8
// vertex: sine lookup, radius scaling, aspect scaling, rotation, rounding.
// ----------------------------------------------------------------------------
module lfvg_xform (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  lfvg_pkg::lfvg_vtx_t vtx_i,
  output logic               res_valid_o,
  output lfvg_pkg::lfvg_res_t res_o
);
  import lfvg_pkg::*;

  function automatic logic signed [RW-1:0] sine_rom(input logic [4:0] idx);
    logic signed [RW-1:0] v;
    case (idx)
      5'd0:    v = 18'sd0;
      5'd1:    v = 18'sd12785;
      5'd2:    v = 18'sd25080;
      5'd3:    v = 18'sd36410;
      5'd4:    v = 18'sd46341;
      5'd5:    v = 18'sd54491;
      5'd6:    v = 18'sd60547;
      5'd7:    v = 18'sd64277;
      5'd8:    v = 18'sd65536;
      5'd9:    v = 18'sd64277;
      5'd10:   v = 18'sd60547;
      5'd11:   v = 18'sd54491;
      5'd12:   v = 18'sd46341;
      5'd13:   v = 18'sd36410;
      5'd14:   v = 18'sd25080;
      5'd15:   v = 18'sd12785;
      5'd16:   v = 18'sd0;
      5'd17:   v = -18'sd12785;
      5'd18:   v = -18'sd25080;
      5'd19:   v = -18'sd36410;
      5'd20:   v = -18'sd46341;
      5'd21:   v = -18'sd54491;
      5'd22:   v = -18'sd60547;
      5'd23:   v = -18'sd64277;
      5'd24:   v = -18'sd65536;
      5'd25:   v = -18'sd64277;
      5'd26:   v = -18'sd60547;
      5'd27:   v = -18'sd54491;
      5'd28:   v = -18'sd46341;
      5'd29:   v = -18'sd36410;
      5'd30:   v = -18'sd25080;
      default: v = -18'sd12785;
    endcase
    return v;
  endfunction

  function automatic logic signed [CW-1:0] sat24(input logic signed [33:0] v);
    logic signed [CW-1:0] r;
    if (v > 34'sd8388607) begin
      r = 24'sd8388607;
    end else if (v < -34'sd8388608) begin
      r = -24'sd8388608;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // stage valids
  logic [7:1] vld_q;

  // stage 1: ROM lookup
  lfvg_tag_t            s1_tag_q;
  lfvg_frame_t          s1_frm_q;
  logic signed [23:0]   s1_rad_q;
  logic signed [15:0]   s1_asp_q;
  logic signed [23:0]   s1_off_q;
  logic                 s1_use_asp_q;
  logic signed [RW-1:0] s1_romx_q;
  logic signed [RW-1:0] s1_romy_q;

  // stage 2: radius scaling
  lfvg_tag_t             s2_tag_q;
  lfvg_frame_t           s2_frm_q;
  logic signed [15:0]    s2_asp_q;
  logic signed [23:0]    s2_off_q;
  logic                  s2_use_asp_q;
  logic signed [MXW-1:0] s2_mx_q, s2_mx_d;
  logic signed [MXW-1:0] s2_my_q, s2_my_d;

  // stage 3: offset add, aspect partial products
  lfvg_tag_t             s3_tag_q;
  lfvg_frame_t           s3_frm_q;
  logic                  s3_use_asp_q;
  logic signed [LXW-1:0] s3_lx_q, s3_lx_d;
  logic signed [MXW-1:0] s3_my_q;
  logic signed [37:0]    s3_ayl_q, s3_ayl_d;
  logic signed [35:0]    s3_ayh_q, s3_ayh_d;

  // stage 4: aspect rounding
  lfvg_tag_t             s4_tag_q;
  lfvg_frame_t           s4_frm_q;
  logic signed [LXW-1:0] s4_lx_q;
  logic signed [LYW-1:0] s4_ly_q, s4_ly_d;
  logic signed [56:0]    asp_sum;

  // stage 5: rotation partial products
  lfvg_tag_t          s5_tag_q;
  logic signed [23:0] s5_cx_q, s5_cy_q;
  logic signed [37:0] s5_pxx_l_q, s5_pxx_l_d, s5_pxy_l_q, s5_pxy_l_d;
  logic signed [36:0] s5_pxx_h_q, s5_pxx_h_d, s5_pxy_h_q, s5_pxy_h_d;
  logic signed [40:0] s5_pyx_l_q, s5_pyx_l_d, s5_pyy_l_q, s5_pyy_l_d;
  logic signed [39:0] s5_pyx_h_q, s5_pyx_h_d, s5_pyy_h_q, s5_pyy_h_d;

  // stage 6: combined products
  lfvg_tag_t              s6_tag_q;
  logic signed [23:0]     s6_cx_q, s6_cy_q;
  logic signed [SUMW-1:0] s6_pxx_q, s6_pxx_d, s6_pxy_q, s6_pxy_d;
  logic signed [SUMW-1:0] s6_pyx_q, s6_pyx_d, s6_pyy_q, s6_pyy_d;

  // stage 7: sums with rounding bias
  lfvg_tag_t              s7_tag_q;
  logic signed [SUMW-1:0] s7_sx_q, s7_sx_d, s7_sy_q, s7_sy_d;

  // output register
  logic      res_valid_q;
  lfvg_res_t res_q, res_d;

  assign s2_mx_d = MXW'(s1_rad_q * s1_romx_q);
  assign s2_my_d = MXW'(s1_rad_q * s1_romy_q);

  assign s3_lx_d  = LXW'(s2_mx_q) + LXW'($signed({s2_off_q, 16'h0000}));
  assign s3_ayl_d = 38'($signed({1'b0, s2_my_q[20:0]}) * s2_asp_q);
  assign s3_ayh_d = 36'($signed(s2_my_q[MXW-1:21]) * s2_asp_q);

  assign asp_sum = (57'(s3_ayh_q) <<< 21) + 57'(s3_ayl_q) + 57'sd128;
  assign s4_ly_d = s3_use_asp_q ? LYW'(asp_sum >>> 8) : LYW'(s3_my_q);

  assign s5_pxx_l_d = 38'($signed({1'b0, s4_lx_q[20:0]}) * s4_frm_q.dx);
  assign s5_pxx_h_d = 37'($signed(s4_lx_q[LXW-1:21]) * s4_frm_q.dx);
  assign s5_pxy_l_d = 38'($signed({1'b0, s4_lx_q[20:0]}) * s4_frm_q.dy);
  assign s5_pxy_h_d = 37'($signed(s4_lx_q[LXW-1:21]) * s4_frm_q.dy);
  assign s5_pyx_l_d = 41'($signed({1'b0, s4_ly_q[23:0]}) * s4_frm_q.dx);
  assign s5_pyx_h_d = 40'($signed(s4_ly_q[LYW-1:24]) * s4_frm_q.dx);
  assign s5_pyy_l_d = 41'($signed({1'b0, s4_ly_q[23:0]}) * s4_frm_q.dy);
  assign s5_pyy_h_d = 40'($signed(s4_ly_q[LYW-1:24]) * s4_frm_q.dy);

  assign s6_pxx_d = (SUMW'(s5_pxx_h_q) <<< 21) + SUMW'(s5_pxx_l_q);
  assign s6_pxy_d = (SUMW'(s5_pxy_h_q) <<< 21) + SUMW'(s5_pxy_l_q);
  assign s6_pyx_d = (SUMW'(s5_pyx_h_q) <<< 24) + SUMW'(s5_pyx_l_q);
  assign s6_pyy_d = (SUMW'(s5_pyy_h_q) <<< 24) + SUMW'(s5_pyy_l_q);

  assign s7_sx_d = SUMW'($signed({s6_cx_q, 1'b1, 29'h0})) + s6_pxx_q - s6_pyy_q;
  assign s7_sy_d = SUMW'($signed({s6_cy_q, 1'b1, 29'h0})) + s6_pyx_q + s6_pxy_q;

  always_comb begin
    res_d.fan_start = s7_tag_q.fan_start;
    res_d.vertex_x  = sat24($signed(s7_sx_q[SUMW-1:30]));
    res_d.vertex_y  = sat24($signed(s7_sy_q[SUMW-1:30]));
    res_d.alpha     = s7_tag_q.alpha;
    res_d.last      = s7_tag_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      vld_q       <= {vld_q[6:1], vld_i};
      res_valid_q <= vld_q[7];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q     <= vtx_i.tag;
    s1_frm_q     <= vtx_i.frame;
    s1_rad_q     <= vtx_i.radius;
    s1_asp_q     <= vtx_i.aspect;
    s1_off_q     <= vtx_i.offset;
    s1_use_asp_q <= vtx_i.use_asp;
    s1_romx_q    <= sine_rom(vtx_i.idx_x);
    s1_romy_q    <= sine_rom(vtx_i.idx_y);

    s2_tag_q     <= s1_tag_q;
    s2_frm_q     <= s1_frm_q;
    s2_asp_q     <= s1_asp_q;
    s2_off_q     <= s1_off_q;
    s2_use_asp_q <= s1_use_asp_q;
    s2_mx_q      <= s2_mx_d;
    s2_my_q      <= s2_my_d;

    s3_tag_q     <= s2_tag_q;
    s3_frm_q     <= s2_frm_q;
    s3_use_asp_q <= s2_use_asp_q;
    s3_lx_q      <= s3_lx_d;
    s3_my_q      <= s2_my_q;
    s3_ayl_q     <= s3_ayl_d;
    s3_ayh_q     <= s3_ayh_d;

    s4_tag_q <= s3_tag_q;
    s4_frm_q <= s3_frm_q;
    s4_lx_q  <= s3_lx_q;
    s4_ly_q  <= s4_ly_d;

    s5_tag_q   <= s4_tag_q;
    s5_cx_q    <= s4_frm_q.cx;
    s5_cy_q    <= s4_frm_q.cy;
    s5_pxx_l_q <= s5_pxx_l_d;
    s5_pxx_h_q <= s5_pxx_h_d;
    s5_pxy_l_q <= s5_pxy_l_d;
    s5_pxy_h_q <= s5_pxy_h_d;
    s5_pyx_l_q <= s5_pyx_l_d;
    s5_pyx_h_q <= s5_pyx_h_d;
    s5_pyy_l_q <= s5_pyy_l_d;
    s5_pyy_h_q <= s5_pyy_h_d;

    s6_tag_q <= s5_tag_q;
    s6_cx_q  <= s5_cx_q;
    s6_cy_q  <= s5_cy_q;
    s6_pxx_q <= s6_pxx_d;
    s6_pxy_q <= s6_pxy_d;
    s6_pyx_q <= s6_pyx_d;
    s6_pyy_q <= s6_pyy_d;

    s7_tag_q <= s6_tag_q;
    s7_sx_q  <= s7_sx_d;
    s7_sy_q  <= s7_sy_d;

    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/light_fan_vertex_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light fan vertex generator
// Expands one light request into the vertices of its triangle fans.
//
// A request transaction is taken on a rising edge with start high and busy
// low. A point light yields 17 vertices, a spot light 33, a direct light 23
// (two fans of 13 and 10); an unknown operation yields none and leaves the
// sequencer idle. The sequencer issues one vertex per cycle while a request
// is active; busy drops during the cycle that issues the final vertex, so
// the next request follows without a gap. Each vertex runs through an
// eight-stage transform pipeline and appears on res_o with res_valid_o high
// for exactly one cycle; res_o.last marks the final one. Throughput is one
// vertex per cycle while a request is active. The receiver cannot stall, so
// the pipeline never holds. Reset clears the sequencer and all stage
// valids; vertices in flight drop.
// ----------------------------------------------------------------------------
module light_fan_vertex_generator_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  lfvg_pkg::lfvg_req_t req_i,
  output logic                res_valid_o,
  output lfvg_pkg::lfvg_res_t res_o
);
  import lfvg_pkg::*;

  localparam logic [4:0] IDX_QUARTER = 5'd8;
  localparam logic [4:0] IDX_HALF    = 5'd16;
  localparam logic [4:0] IDX_3Q      = 5'd24;

  localparam logic [5:0] POINT_LAST     = 6'd16;
  localparam logic [5:0] SPOT_LAST      = 6'd32;
  localparam logic [5:0] DIR_DISC_LAST  = 6'd9;
  localparam logic [5:0] DIR_BEAM_LOW   = 6'd10;
  localparam logic [5:0] DIR_BEAM_MID   = 6'd11;
  localparam logic [5:0] DIR_BEAM_HIGH  = 6'd12;
  localparam logic [5:0] DIR_CAP_CENTER = 6'd13;
  localparam logic [5:0] DIR_CAP_FIRST  = 6'd14;
  localparam logic [5:0] DIR_LAST       = 6'd22;

  localparam logic signed [15:0] DIR_UNIT = 16'sd16384;

  lfvg_req_t  req_q;
  logic [7:0] alpha_q, alpha_d;
  logic [5:0] cnt_q;
  logic       active_q;
  logic       accept;

  lfvg_vtx_t  vtx;
  logic [4:0] i5, dbl, cap_j, cap_dbl;
  logic [22:0] a_prod;
  logic [14:0] a_t;

  // alpha = clamp(floor(255 * intensity / 256), 0, 255)
  always_comb begin
    a_prod = {req_i.intensity[14:0], 8'h00} - {8'h00, req_i.intensity[14:0]};
    a_t    = a_prod[22:8];
    if (req_i.intensity[15] || (req_i.intensity == 16'sd0)) begin
      alpha_d = 8'h00;
    end else if (a_t > 15'd255) begin
      alpha_d = 8'hff;
    end else begin
      alpha_d = a_t[7:0];
    end
  end

  always_comb begin
    i5      = 5'(cnt_q - 6'd1);
    dbl     = {i5[3:0], 1'b0};
    cap_j   = 5'(cnt_q - DIR_CAP_FIRST);
    cap_dbl = {cap_j[3:0], 1'b0};

    vtx.tag.fan_start = (cnt_q == 6'd0);
    vtx.tag.alpha     = (cnt_q == 6'd0) ? alpha_q : 8'h00;
    vtx.tag.last      = 1'b0;
    vtx.frame.cx      = req_q.center_x;
    vtx.frame.cy      = req_q.center_y;
    vtx.frame.dx      = req_q.dir_x;
    vtx.frame.dy      = req_q.dir_y;
    vtx.radius        = req_q.radius;
    vtx.aspect        = req_q.aspect;
    vtx.offset        = '0;
    vtx.use_asp       = 1'b0;
    vtx.idx_x         = '0;
    vtx.idx_y         = '0;

    unique case (op_e'(req_q.operation))
      OP_POINT: begin
        vtx.frame.dx = DIR_UNIT;
        vtx.frame.dy = '0;
        vtx.tag.last = (cnt_q == POINT_LAST);
        if (cnt_q != 6'd0) begin
          vtx.idx_x = dbl + IDX_QUARTER;
          vtx.idx_y = dbl;
        end
      end
      OP_SPOT: begin
        vtx.tag.last = (cnt_q == SPOT_LAST);
        if (cnt_q != 6'd0) begin
          vtx.idx_x   = i5 + IDX_QUARTER;
          vtx.idx_y   = i5;
          vtx.offset  = req_q.shift;
          vtx.use_asp = 1'b1;
        end
      end
      OP_DIRECT: begin
        vtx.tag.last = (cnt_q == DIR_LAST);
        if (cnt_q == 6'd0) begin
          vtx.idx_x = '0;
        end else if (cnt_q <= DIR_DISC_LAST) begin
          vtx.idx_x = dbl + IDX_HALF;
          vtx.idx_y = dbl + IDX_QUARTER;
        end else if (cnt_q == DIR_BEAM_LOW) begin
          vtx.offset = req_q.beam_length;
          vtx.idx_y  = IDX_3Q;
        end else if (cnt_q == DIR_BEAM_MID) begin
          vtx.offset    = req_q.beam_length;
          vtx.tag.alpha = alpha_q;
        end else if (cnt_q == DIR_BEAM_HIGH) begin
          vtx.offset = req_q.beam_length;
          vtx.idx_y  = IDX_QUARTER;
        end else if (cnt_q == DIR_CAP_CENTER) begin
          vtx.offset        = req_q.beam_length;
          vtx.tag.alpha     = alpha_q;
          vtx.tag.fan_start = 1'b1;
        end else begin
          vtx.offset = req_q.beam_length;
          vtx.idx_x  = cap_dbl;
          vtx.idx_y  = cap_dbl + IDX_QUARTER;
        end
      end
      default: begin
        vtx.tag.last = 1'b1;
      end
    endcase
  end

  assign busy   = active_q && !vtx.tag.last;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else if (accept) begin
      active_q <= (req_i.operation inside {OP_POINT, OP_SPOT, OP_DIRECT});
      cnt_q    <= '0;
    end else if (active_q) begin
      if (vtx.tag.last) begin
        active_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_i;
      alpha_q <= alpha_d;
    end
  end

  lfvg_xform u_xform (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (active_q),
    .vtx_i       (vtx),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light fan vertex generator testbench
// Drives point, spot, direct and unknown light requests through the command
// handshake, predicts each triangle-fan vertex from a sine-table model of the
// fan geometry, and checks every vertex transaction in order against it.
// ----------------------------------------------------------------------------
module tb_top;

  import lfvg_pkg::*;

  localparam logic [1:0] OpUnknown = 2'd3;
  localparam int         ClkHalf   = 6;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  lfvg_req_t  req_i = '0;
  logic       res_valid_o;
  lfvg_res_t  res_o;

  lfvg_res_t  pending_vertices[$];
  int         mismatch_count = 0;
  bit         idle_enabled = 1'b1;

  light_fan_vertex_generator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  function automatic longint sine_q16(input int idx);
    int     k;
    int     q;
    longint mag;
    k = idx & 31;
    q = k & 15;
    if (q > 8) q = 16 - q;
    case (q)
      0: mag = 0;
      1: mag = 12785;
      2: mag = 25080;
      3: mag = 36410;
      4: mag = 46341;
      5: mag = 54491;
      6: mag = 60547;
      7: mag = 64277;
      default: mag = 65536;
    endcase
    return (k >= 16) ? -mag : mag;
  endfunction

  function automatic logic [23:0] clamp_q15_8(input longint v);
    if (v > 64'sd8388607) return 24'h7FFFFF;
    if (v < -64'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

  function automatic lfvg_res_t transform_vertex(input longint cx, cy, dx, dy,
                                                 input logic fs,
                                                 input longint lx, ly,
                                                 input logic [7:0] a);
    longint    x;
    longint    y;
    lfvg_res_t v;
    x = (cx <<< 30) + lx * dx - ly * dy;
    y = (cy <<< 30) + ly * dx + lx * dy;
    v.fan_start = fs;
    v.vertex_x  = clamp_q15_8((x + (64'sd1 <<< 29)) >>> 30);
    v.vertex_y  = clamp_q15_8((y + (64'sd1 <<< 29)) >>> 30);
    v.alpha     = a;
    v.last      = 1'b0;
    return v;
  endfunction

  task automatic predict_light_vertices(input lfvg_req_t r);
    longint     cx, cy, dx, dy, rad, sh, asp, len, inten, t, lx, ly, ll, lr;
    logic [7:0] a;
    lfvg_res_t  fan[$];
    cx    = longint'(r.center_x);
    cy    = longint'(r.center_y);
    dx    = longint'(r.dir_x);
    dy    = longint'(r.dir_y);
    rad   = longint'(r.radius);
    sh    = longint'(r.shift);
    asp   = longint'(r.aspect);
    len   = longint'(r.beam_length);
    inten = longint'(r.intensity);
    if (inten <= 0) begin
      a = 8'd0;
    end else begin
      t = (255 * inten) >>> 8;
      a = (t > 255) ? 8'd255 : t[7:0];
    end
    case (r.operation)
      OP_POINT: begin
        fan.push_back(transform_vertex(cx, cy, 16384, 0, 1'b1, 0, 0, a));
        for (int i = 0; i < 16; i++) begin
          fan.push_back(transform_vertex(cx, cy, 16384, 0, 1'b0,
                                         rad * sine_q16(2 * i + 8),
                                         rad * sine_q16(2 * i), 8'd0));
        end
      end
      OP_SPOT: begin
        fan.push_back(transform_vertex(cx, cy, dx, dy, 1'b1, 0, 0, a));
        for (int i = 0; i < 32; i++) begin
          lx = (sh <<< 16) + rad * sine_q16(i + 8);
          ly = (rad * sine_q16(i) * asp + 128) >>> 8;
          fan.push_back(transform_vertex(cx, cy, dx, dy, 1'b0, lx, ly, 8'd0));
        end
      end
      OP_DIRECT: begin
        ll = len <<< 16;
        lr = rad <<< 16;
        fan.push_back(transform_vertex(cx, cy, dx, dy, 1'b1, 0, 0, a));
        for (int i = 0; i <= 8; i++) begin
          fan.push_back(transform_vertex(cx, cy, dx, dy, 1'b0,
                                         -(rad * sine_q16(2 * i)),
                                         rad * sine_q16(2 * i + 8), 8'd0));
        end
        fan.push_back(transform_vertex(cx, cy, dx, dy, 1'b0, ll, -lr, 8'd0));
        fan.push_back(transform_vertex(cx, cy, dx, dy, 1'b0, ll, 0, a));
        fan.push_back(transform_vertex(cx, cy, dx, dy, 1'b0, ll, lr, 8'd0));
        fan.push_back(transform_vertex(cx, cy, dx, dy, 1'b1, ll, 0, a));
        for (int i = 0; i <= 8; i++) begin
          fan.push_back(transform_vertex(cx, cy, dx, dy, 1'b0,
                                         rad * sine_q16(2 * i) + ll,
                                         rad * sine_q16(2 * i + 8), 8'd0));
        end
      end
      default: ;
    endcase
    if (fan.size() > 0) fan[fan.size() - 1].last = 1'b1;
    foreach (fan[i]) pending_vertices.push_back(fan[i]);
  endtask

  function automatic lfvg_req_t light_request(input logic [1:0] op, input int inten,
                                              input int rad, input int cx, input int cy,
                                              input int dxv, input int dyv,
                                              input int sh, input int asp,
                                              input int len);
    lfvg_req_t r;
    r.operation   = op;
    r.intensity   = inten[15:0];
    r.radius      = rad[23:0];
    r.center_x    = cx[23:0];
    r.center_y    = cy[23:0];
    r.dir_x       = dxv[15:0];
    r.dir_y       = dyv[15:0];
    r.shift       = sh[23:0];
    r.aspect      = asp[15:0];
    r.beam_length = len[23:0];
    return r;
  endfunction

  task automatic send_request(input lfvg_req_t r);
    int gap;
    gap = (idle_enabled && $urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predict_light_vertices(r);
  endtask

  task automatic flag_mismatch(input string field, input longint e, input longint a);
    $display("%0t ns: %s expected %0d, got %0d", $time, field, e, a);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    lfvg_res_t exp_v;
    if (rst_ni && res_valid_o) begin
      if (pending_vertices.size() == 0) begin
        $display("%0t ns: unexpected vertex expected none, got %h", $time, res_o);
        mismatch_count++;
      end else begin
        exp_v = pending_vertices.pop_front();
        if (res_o.fan_start !== exp_v.fan_start)
          flag_mismatch("fan_start", exp_v.fan_start, res_o.fan_start);
        if (res_o.vertex_x !== exp_v.vertex_x)
          flag_mismatch("vertex_x", longint'(exp_v.vertex_x), longint'(res_o.vertex_x));
        if (res_o.vertex_y !== exp_v.vertex_y)
          flag_mismatch("vertex_y", longint'(exp_v.vertex_y), longint'(res_o.vertex_y));
        if (res_o.alpha !== exp_v.alpha)
          flag_mismatch("alpha", exp_v.alpha, res_o.alpha);
        if (res_o.last !== exp_v.last)
          flag_mismatch("last", exp_v.last, res_o.last);
      end
    end
  end

  task automatic test_point_lights();
    send_request(light_request(OP_POINT, 256, 2560, 25600, 12800, 7, -3, 0, 0, 0));
    send_request(light_request(OP_POINT, 32767, 8388607, 8388607, 8388607,
                               -32768, 32767, 8388607, 32767, 8388607));
    send_request(light_request(OP_POINT, -32768, -8388608, -8388608, -8388608,
                               32767, -32768, -8388608, -32768, -8388608));
  endtask

  task automatic test_spot_lights();
    send_request(light_request(OP_SPOT, 128, 5120, 2560, -2560, 16384, 0, 1280, 256, 0));
    send_request(light_request(OP_SPOT, 200, 3000, -40000, 90000, 11585, 11585,
                               -700, 512, 0));
    send_request(light_request(OP_SPOT, 300, 8388607, 0, 0, -16384, 16384,
                               8388607, -32768, 0));
    send_request(light_request(OP_SPOT, 64, -8388608, 8388607, -8388608, 32767, -32768,
                               -8388608, 32767, 0));
    send_request(light_request(OP_SPOT, 1, 4096, 100, 200, -32768, 32767, 0, -256, 0));
  endtask

  task automatic test_direct_lights();
    send_request(light_request(OP_DIRECT, 256, 1024, 51200, 51200, 0, 16384, 0, 0, 25600));
    send_request(light_request(OP_DIRECT, 180, 2048, -3000, 4000, -11585, 11585,
                               0, 0, -12800));
    send_request(light_request(OP_DIRECT, 32767, 8388607, 8388607, -8388608,
                               16384, -16384, 0, 0, 8388607));
    send_request(light_request(OP_DIRECT, 500, -8388608, -8388608, 8388607,
                               -32768, 32767, 0, 0, -8388608));
  endtask

  task automatic test_intensity_and_unknown();
    send_request(light_request(OP_POINT, 0, 512, 0, 0, 0, 0, 0, 0, 0));
    send_request(light_request(OP_SPOT, -1, 512, 0, 0, 16384, 0, 0, 256, 0));
    send_request(light_request(OP_DIRECT, 1, 512, 0, 0, 16384, 0, 0, 0, 512));
    send_request(light_request(OP_POINT, 257, 512, 0, 0, 0, 0, 0, 0, 0));
    send_request(light_request(OpUnknown, 256, 512, 100, 100, 16384, 0, 0, 256, 512));
    send_request(light_request(OpUnknown, -32768, -8388608, -8388608, 8388607,
                               -32768, 32767, 8388607, -32768, 8388607));
    send_request(light_request(OP_POINT, 255, 768, -256, 256, 0, 0, 0, 0, 0));
  endtask

  function automatic lfvg_req_t random_light();
    logic [191:0] bits;
    lfvg_req_t    r;
    int           k;
    int           roll;
    if ($urandom_range(0, 3) == 0) begin
      bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      r = bits[185:0];
    end else begin
      k = $urandom_range(0, 31);
      r = light_request(OP_POINT,
                        int'($urandom_range(0, 640)) - 64,
                        int'($urandom_range(0, 32768)) - 2048,
                        int'($urandom_range(0, 2097152)) - 1048576,
                        int'($urandom_range(0, 2097152)) - 1048576,
                        int'(sine_q16(k + 8) >>> 2),
                        int'(sine_q16(k) >>> 2),
                        int'($urandom_range(0, 16384)) - 8192,
                        int'($urandom_range(0, 1024)) - 128,
                        int'($urandom_range(0, 65536)) - 8192);
    end
    roll = $urandom_range(0, 15);
    r.operation = (roll == 0) ? OpUnknown : 2'($urandom_range(0, 2));
    return r;
  endfunction

  task automatic test_random_lights(input int count);
    repeat (count) send_request(random_light());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_point_lights();
    test_spot_lights();
    test_direct_lights();
    test_intensity_and_unknown();
    test_random_lights(280);
    idle_enabled = 1'b0;
    test_random_lights(50);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
